// ----- rtl/core/priority_schedule_times_core_assert.svh -----
// assertion macros for the priority schedule core checker
// expects signals named clk and rst in the scope of use
`ifndef PRIORITY_SCHEDULE_TIMES_CORE_ASSERT_SVH
`define PRIORITY_SCHEDULE_TIMES_CORE_ASSERT_SVH

// antecedent implies consequent in the next cycle, idle during reset
`define PST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority schedule core check failed");

// same, but also checked while reset is high
`define PST_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("priority schedule core reset check failed");

`endif

// ----- rtl/core/pst_pkg.sv -----
// shared constants and types for the priority schedule core
// used by the controller, the datapath and the top level
package pst_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int WAIT_W  = 20;
  localparam int WSUM_W  = 23;
  localparam int TSUM_W  = 24;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } pst_entry_t;

  // controller to datapath
  typedef struct packed {
    logic             load_we;    // store the incoming word
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] pos;        // table slot of the data now arriving
    logic             take_first; // head of a pass: seed the minimum
    logic             compare;    // scan step: keep the smaller priority
    logic             emit;       // swap and load the output register
    logic             final_pos;
    logic             clear_acc;
  } pst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } pst_status_t;

endpackage

// ----- rtl/core/pst_in_if.sv -----
// job input channel of the priority schedule core
// standalone, no package dependency
interface pst_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] job_id;
  logic [15:0] burst_length;
  logic [7:0]  job_priority;
  logic        last_job;

  modport source (output valid, job_id, burst_length, job_priority, last_job, input ready);
  modport sink (input valid, job_id, burst_length, job_priority, last_job, output ready);
endinterface

// ----- rtl/core/pst_out_if.sv -----
// result output channel of the priority schedule core
// standalone, no package dependency
interface pst_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_job_id;
  logic [15:0] out_burst;
  logic [19:0] wait_time;
  logic [19:0] turnaround;
  logic [22:0] wait_sum;
  logic [23:0] turnaround_sum;
  logic        final_result;

  modport source (output valid, out_job_id, out_burst, wait_time, turnaround, wait_sum,
                  turnaround_sum, final_result, input ready);
  modport sink (input valid, out_job_id, out_burst, wait_time, turnaround, wait_sum,
                turnaround_sum, final_result, output ready);
endinterface

// ----- rtl/core/pst_datapath.sv -----
// datapath: job table memory, running minimum, timing sums, output register
// depends on pst_pkg and pst_out_if
module pst_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  pst_pkg::pst_cmd_t     cmd,
  input  pst_pkg::pst_entry_t   in_entry,
  output pst_pkg::pst_status_t  status,
  pst_out_if.source             results
);

  pst_pkg::pst_entry_t mem [pst_pkg::MAX_PROCS];
  pst_pkg::pst_entry_t rd_data;
  pst_pkg::pst_entry_t cur;
  pst_pkg::pst_entry_t best;
  logic [pst_pkg::IDX_W-1:0] best_pos;

  logic [pst_pkg::WAIT_W-1:0] elapsed;
  logic [pst_pkg::WSUM_W-1:0] wsum;
  logic [pst_pkg::TSUM_W-1:0] tsum;

  logic [pst_pkg::WAIT_W:0]   turn_raw;
  logic [pst_pkg::WAIT_W-1:0] turn_next;
  logic [pst_pkg::WSUM_W:0]   wsum_raw;
  logic [pst_pkg::WSUM_W-1:0] wsum_next;
  logic [pst_pkg::TSUM_W:0]   tsum_raw;
  logic [pst_pkg::TSUM_W-1:0] tsum_next;

  logic out_valid;

  // table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem[cmd.wr_addr] <= in_entry;
    end else if (cmd.emit) begin
      mem[best_pos] <= cur;
    end
    rd_data <= mem[cmd.rd_addr];
  end

  // running minimum of the current pass, strict compare keeps the first hit
  always_ff @(posedge clk) begin
    if (cmd.take_first) begin
      cur      <= rd_data;
      best     <= rd_data;
      best_pos <= cmd.pos;
    end else if (cmd.compare && (rd_data.prio < best.prio)) begin
      best     <= rd_data;
      best_pos <= cmd.pos;
    end
  end

  always_comb begin
    turn_raw  = {1'b0, elapsed} + (pst_pkg::WAIT_W + 1)'(best.burst);
    turn_next = turn_raw[pst_pkg::WAIT_W] ? '1 : turn_raw[pst_pkg::WAIT_W-1:0];
    wsum_raw  = {1'b0, wsum} + (pst_pkg::WSUM_W + 1)'(elapsed);
    wsum_next = wsum_raw[pst_pkg::WSUM_W] ? '1 : wsum_raw[pst_pkg::WSUM_W-1:0];
    tsum_raw  = {1'b0, tsum} + (pst_pkg::TSUM_W + 1)'(turn_next);
    tsum_next = tsum_raw[pst_pkg::TSUM_W] ? '1 : tsum_raw[pst_pkg::TSUM_W-1:0];
  end

  // elapsed is kept clipped at the wait width, which leaves every wait value unchanged
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_acc) begin
      elapsed <= '0;
      wsum    <= '0;
      tsum    <= '0;
    end else if (cmd.emit) begin
      elapsed <= turn_next;
      wsum    <= wsum_next;
      tsum    <= tsum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.out_job_id     <= best.id;
      results.out_burst      <= best.burst;
      results.wait_time      <= elapsed;
      results.turnaround     <= turn_next;
      results.wait_sum       <= wsum_next;
      results.turnaround_sum <= tsum_next;
      results.final_result   <= cmd.final_pos;
    end
  end

  assign results.valid   = out_valid;
  assign status.out_free = !out_valid || results.ready;

endmodule

// ----- rtl/core/pst_ctrl.sv -----
// controller: load sequencing, selection sort passes and emit handshake
// depends on pst_pkg
module pst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  pst_pkg::pst_status_t status,
  output pst_pkg::pst_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_HEAD,
    ST_PASS_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state;
  logic [pst_pkg::CNT_W-1:0] count;
  logic [pst_pkg::CNT_W-1:0] i;
  logic [pst_pkg::CNT_W-1:0] j;
  logic [pst_pkg::CNT_W-1:0] data_pos;

  logic accept;
  logic room;
  logic more;
  logic last_pos;

  assign accept   = (state == ST_LOAD) && in_valid;
  assign room     = count < pst_pkg::CNT_W'(pst_pkg::MAX_PROCS);
  assign more     = j < count;
  assign last_pos = (i + pst_pkg::CNT_W'(1)) == count;
  assign in_ready = (state == ST_LOAD);

  always_comb begin
    cmd            = '0;
    cmd.wr_addr    = count[pst_pkg::IDX_W-1:0];
    cmd.load_we    = accept && room;
    cmd.clear_acc  = accept && in_last;
    cmd.final_pos  = last_pos;
    cmd.take_first = (state == ST_PASS_LOAD);
    cmd.compare    = (state == ST_SCAN);
    cmd.emit       = (state == ST_EMIT) && status.out_free;
    cmd.pos        = (state == ST_PASS_LOAD) ? i[pst_pkg::IDX_W-1:0]
                                             : data_pos[pst_pkg::IDX_W-1:0];
    cmd.rd_addr    = (state == ST_PASS_HEAD) ? i[pst_pkg::IDX_W-1:0]
                                             : j[pst_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      i        <= '0;
      j        <= '0;
      data_pos <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + pst_pkg::CNT_W'(1);
            end
            if (in_last) begin
              i     <= '0;
              state <= ST_PASS_HEAD;
            end
          end
        end
        ST_PASS_HEAD: begin
          j     <= i + pst_pkg::CNT_W'(1);
          state <= ST_PASS_LOAD;
        end
        ST_PASS_LOAD, ST_SCAN: begin
          if (more) begin
            data_pos <= j;
            j        <= j + pst_pkg::CNT_W'(1);
            state    <= ST_SCAN;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (status.out_free) begin
            i <= i + pst_pkg::CNT_W'(1);
            if (last_pos) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              state <= ST_PASS_HEAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/priority_schedule_times_core.sv -----
// priority schedule core: batches jobs and emits a non-preemptive priority schedule
// with waiting and turnaround times; uses pst_pkg, pst_in_if, pst_out_if,
// pst_ctrl and pst_datapath
//
// jobs: one word per job (id, burst, priority, last flag), one cycle each while
// loading. up to 16 jobs are held; further jobs are dropped, but a dropped word
// that carries the last flag still closes the set. jobs.ready is low from the
// closing word until the final result of the set has been loaded for output.
// results: one word per stored job in ascending priority order, ties in
// selection sort order, with waiting time, turnaround and the running sums;
// final_result marks the last word of the set.
// sort: each pass k waits out the registered table read, seeds the minimum
// from slot k, makes one compare per table read over the later slots, then
// swaps and emits; the single read port of the job table paces the scan.
// a stalled receiver holds the output register and the sort pauses at the
// next emit; nothing is lost.
// reset (synchronous, active high) empties the table and drops any result.
module priority_schedule_times_core (
  input logic       clk,
  input logic       rst,
  pst_in_if.sink    jobs,
  pst_out_if.source results
);

  pst_pkg::pst_cmd_t    cmd;
  pst_pkg::pst_status_t status;
  pst_pkg::pst_entry_t  in_entry;

  assign in_entry.id    = jobs.job_id;
  assign in_entry.burst = jobs.burst_length;
  assign in_entry.prio  = jobs.job_priority;

  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (jobs.valid),
    .in_last  (jobs.last_job),
    .in_ready (jobs.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pst_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_entry (in_entry),
    .status   (status),
    .results  (results)
  );

endmodule

// ----- rtl/core/pst_checker.sv -----
// port level checks for the priority schedule core, bound to the top level
// depends on priority_schedule_times_core_assert.svh
`include "priority_schedule_times_core_assert.svh"

module pst_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_final
);

  // a stalled result word stays offered
  `PST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // the closing word starts the sort, so no job is taken next
  `PST_ASSERT_NEXT(a_close_blocks, in_valid && in_ready && in_last, !in_ready)
  // after a non-final word the set stays busy unless its final word was loaded in that cycle
  `PST_ASSERT_NEXT(a_set_busy, out_valid && out_ready && !out_final, !in_ready || (out_valid && out_final))
  // reset drops any offered result
  `PST_ASSERT_NEXT_RST(a_rst_clear, rst, !out_valid)

endmodule

bind priority_schedule_times_core pst_checker u_pst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (jobs.valid),
  .in_ready  (jobs.ready),
  .in_last   (jobs.last_job),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_final (results.final_result)
);

// ----- bench/priority_schedule_times_core_tb.sv -----
// testbench for priority_schedule_times_core: loads job sets and checks every schedule word
// against an in-bench priority scheduler; needs pst_pkg, pst_in_if, pst_out_if and the core
module priority_schedule_times_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pst_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned WORD_TARGET = 230;
  localparam int unsigned CALM_FROM = 190;
  localparam longint unsigned WAIT_TOP = (64'd1 << WAIT_W) - 1;
  localparam longint unsigned WSUM_TOP = (64'd1 << WSUM_W) - 1;
  localparam longint unsigned TSUM_TOP = (64'd1 << TSUM_W) - 1;

  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst;
    logic [WAIT_W-1:0]  wait_time;
    logic [WAIT_W-1:0]  turnaround;
    logic [WSUM_W-1:0]  wait_sum;
    logic [TSUM_W-1:0]  turn_sum;
    logic               is_final;
  } sched_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last;
    logic               has_exp;
    sched_word_t        exp_word;
  } plan_row_t;

  logic clk;
  logic rst;

  pst_in_if  jobs_if ();
  pst_out_if res_if ();

  priority_schedule_times_core u_top (
    .clk     (clk),
    .rst     (rst),
    .jobs    (jobs_if),
    .results (res_if)
  );

  // scheduler state kept alongside the block
  pst_entry_t  job_store [MAX_PROCS];
  int unsigned stored_jobs;
  sched_word_t expected_q [$];
  plan_row_t   plan [$];

  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned sets_closed;
  int unsigned dropped_jobs;
  int unsigned results_checked;
  int unsigned cycles;
  int unsigned gap_pct;
  bit          calm;
  bit          hold_req;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d schedule words outstanding", cycles,
               expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint unsigned clip(longint unsigned v, longint unsigned top);
    return (v > top) ? top : v;
  endfunction

  // stores one job word; on the closing word sorts the batch and books its schedule
  function automatic int unsigned schedule_job(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                                               logic [PRIO_W-1:0] prio, logic last);
    pst_entry_t        tmp;
    int unsigned       pick;
    int unsigned       n;
    longint unsigned   elapsed;
    longint unsigned   w;
    longint unsigned   t;
    longint unsigned   wsum;
    longint unsigned   tsum;
    sched_word_t       r;
    if (stored_jobs < MAX_PROCS) begin
      job_store[stored_jobs].id    = id;
      job_store[stored_jobs].burst = burst;
      job_store[stored_jobs].prio  = prio;
      stored_jobs++;
    end else begin
      dropped_jobs++;
    end
    if (!last) return 0;
    n = stored_jobs;
    // selection sort: first strictly smaller entry wins, then swap into place
    for (int i = 0; i < n; i++) begin
      pick = i;
      for (int j = i + 1; j < n; j++)
        if (job_store[j].prio < job_store[pick].prio) pick = j;
      tmp             = job_store[i];
      job_store[i]    = job_store[pick];
      job_store[pick] = tmp;
    end
    elapsed = 0;
    wsum    = 0;
    tsum    = 0;
    for (int k = 0; k < n; k++) begin
      w    = clip(elapsed, WAIT_TOP);
      t    = clip(job_store[k].burst + w, WAIT_TOP);
      wsum = clip(wsum + w, WSUM_TOP);
      tsum = clip(tsum + t, TSUM_TOP);
      r.job_id     = job_store[k].id;
      r.burst      = job_store[k].burst;
      r.wait_time  = w[WAIT_W-1:0];
      r.turnaround = t[WAIT_W-1:0];
      r.wait_sum   = wsum[WSUM_W-1:0];
      r.turn_sum   = tsum[TSUM_W-1:0];
      r.is_final   = (k + 1 == n);
      expected_q.push_back(r);
      elapsed = clip(elapsed + job_store[k].burst, 64'hFFFF_FFFF);
    end
    stored_jobs = 0;
    return n;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
    mismatches++;
    if (mismatches <= 20)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got_v, want_v);
  endtask

  task automatic check_field(string what, longint unsigned got_v, longint unsigned want_v);
    if (got_v != want_v) report_mismatch(what, got_v, want_v);
  endtask

  always @(posedge clk) begin
    sched_word_t got;
    sched_word_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.job_id     = res_if.out_job_id;
      got.burst      = res_if.out_burst;
      got.wait_time  = res_if.wait_time;
      got.turnaround = res_if.turnaround;
      got.wait_sum   = res_if.wait_sum;
      got.turn_sum   = res_if.turnaround_sum;
      got.is_final   = res_if.final_result;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected schedule word, job id", got.job_id, 0);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        check_field("out_job_id", got.job_id, want.job_id);
        check_field("out_burst", got.burst, want.burst);
        check_field("wait_time", got.wait_time, want.wait_time);
        check_field("turnaround", got.turnaround, want.turnaround);
        check_field("wait_sum", got.wait_sum, want.wait_sum);
        check_field("turnaround_sum", got.turn_sum, want.turn_sum);
        check_field("final_result", got.is_final, want.is_final);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request, none in the calm tail
  initial begin
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req  = 1'b0;
        hold_done = 1'b1;
      end else if (calm) begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic put_job(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                         logic [PRIO_W-1:0] prio, logic last, logic has_exp,
                         sched_word_t exp_word);
    jobs_if.valid        <= 1'b1;
    jobs_if.job_id       <= id;
    jobs_if.burst_length <= burst;
    jobs_if.job_priority <= prio;
    jobs_if.last_job     <= last;
    do @(posedge clk); while (!jobs_if.ready);
    words_sent++;
    if (schedule_job(id, burst, prio, last) > 0) begin
      sets_closed++;
      // a typed-in word replaces the computed one for the closing word
      if (has_exp) expected_q[expected_q.size() - 1] = exp_word;
    end
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      jobs_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  function automatic void add_row(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                                  logic [PRIO_W-1:0] prio, logic last, logic has_exp,
                                  sched_word_t exp_word);
    plan_row_t r;
    r.id       = id;
    r.burst    = burst;
    r.prio     = prio;
    r.last     = last;
    r.has_exp  = has_exp;
    r.exp_word = exp_word;
    plan.push_back(r);
  endfunction

  task automatic send_set(int unsigned n, bit narrow);
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    int unsigned        base;
    base = $urandom_range(0, 252);
    for (int i = 0; i < n; i++) begin
      id = ID_W'($urandom);
      case ($urandom_range(0, 5))
        0: burst = '0;
        1: burst = '1;
        2: burst = BURST_W'($urandom_range(0, 15));
        default: burst = BURST_W'($urandom);
      endcase
      // narrow priority spread forces ties through the unstable sort
      prio = narrow ? PRIO_W'(base + $urandom_range(0, 3)) : PRIO_W'($urandom_range(0, 255));
      put_job(id, burst, prio, i == n - 1, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned n;
    rst                  <= 1'b1;
    jobs_if.valid        <= 1'b0;
    jobs_if.job_id       <= '0;
    jobs_if.burst_length <= '0;
    jobs_if.job_priority <= '0;
    jobs_if.last_job     <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // lone jobs at both extremes
    add_row(16'hffff, 16'hffff, 8'hff, 1'b1, 1'b1,
            '{16'hffff, 16'hffff, 20'd0, 20'hfffff & 20'hffff, 23'd0, 24'hffff, 1'b1});
    add_row(16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, '{default: '0, is_final: 1'b1});
    // ties on two priority levels
    add_row(16'h0001, 16'd10, 8'd5, 1'b0, 1'b0, '0);
    add_row(16'h0002, 16'd20, 8'd3, 1'b0, 1'b0, '0);
    add_row(16'h0003, 16'd30, 8'd5, 1'b0, 1'b0, '0);
    add_row(16'h0004, 16'd40, 8'd3, 1'b0, 1'b0, '0);
    add_row(16'h0005, 16'd50, 8'd5, 1'b1, 1'b0, '0);
    // full table of longest bursts, then a dropped word and a dropped closing word
    for (int k = 0; k < MAX_PROCS; k++)
      add_row(ID_W'(16'h0100 + k), 16'hffff, 8'h80, 1'b0, 1'b0, '0);
    add_row(16'h0200, 16'h1234, 8'h00, 1'b0, 1'b0, '0);
    add_row(16'h0201, 16'h4321, 8'h00, 1'b1, 1'b1,
            '{16'h010f, 16'hffff, 20'd983025, 20'd1048560, 23'd7864200, 24'd8912760, 1'b1});

    gap_pct = 30;
    foreach (plan[i])
      put_job(plan[i].id, plan[i].burst, plan[i].prio, plan[i].last, plan[i].has_exp,
              plan[i].exp_word);

    // long receiver hold-off while two full sets are offered back to back
    gap_pct  = 0;
    hold_req = 1'b1;
    send_set(MAX_PROCS, 1'b0);
    send_set(MAX_PROCS, 1'b1);

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 7) == 0) n = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3);
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 3);
      else n = $urandom_range(1, MAX_PROCS);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      if (words_sent >= CALM_FROM) calm = 1'b1;
      send_set(n, 1'($urandom_range(0, 1)));
    end
    jobs_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d job words in %0d sets, %0d dropped on a full table", words_sent,
             sets_closed, dropped_jobs);
    $display("checked %0d schedule words, long output hold-off %0s", results_checked,
             hold_done ? "done" : "missed");
    if (mismatches == 0 && expected_q.size() == 0 && hold_done) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pst_pkg.sv
rtl/core/pst_in_if.sv
rtl/core/pst_out_if.sv
rtl/core/pst_datapath.sv
rtl/core/pst_ctrl.sv
rtl/core/priority_schedule_times_core.sv
rtl/core/pst_checker.sv
bench/priority_schedule_times_core_tb.sv
